>>> rtl/core/ssa_pkg.sv
// Package for the segmented slot allocator.
// Holds slot, queue and status constants used by the allocator RTL and its testbench.
// No dependencies.
package ssa_pkg;

	localparam int SLOT_W   = 7;
	localparam int COUNT_W  = 8;
	localparam int STATUS_W = 2;
	localparam int QUEUE_DEPTH = 128;
	localparam int QADDR_W  = 7;
	localparam int FILL_W   = 8;

	localparam logic [COUNT_W-1:0] SLOT_LIMIT = 8'd128;
	localparam logic [COUNT_W-1:0] COUNT_MAX  = 8'd255;
	localparam logic [FILL_W-1:0]  FILL_FULL  = 8'd128;

	typedef enum logic {
		CMD_ALLOC   = 1'b0,
		CMD_RELEASE = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_NO_ROOM  = 2'd1,
		ST_REJECTED = 2'd2
	} status_t;

	typedef struct packed {
		logic [4:0]         segments_used;
		logic [COUNT_W-1:0] live_count;
		logic               opened_segment;
		logic               reused;
		status_t            status;
		logic [SLOT_W-1:0]  granted_slot;
	} result_t;

endpackage

>>> rtl/core/segmented_slot_allocator.sv
// Segmented slot allocator top level: FIFO free queue plus bump pointer over segments.
// Depends on ssa_pkg and ssa_ram.
//
// channel  dir  handshake              payload
// s_*      in   s_tvalid / s_tready    s_tuser = cmd, s_tdata[6:0] = slot
// m_*      out  m_tvalid / m_tready    m_tdata = granted_slot, status, reused,
//                                      opened_segment, live_count, segments_used
//
// One request per cycle while the output is not stalled: an input register feeds
// one pass of counter and queue logic into the output register that m_tdata shows.
// The free queue head is prefetched from the RAM every cycle, with a bypass for a
// write to the same entry. Reset clears all counters and pointers; the queue RAM is
// not cleared. A stalled output holds the input stage, which then drops s_tready.
module segmented_slot_allocator
	import ssa_pkg::*;
#(
	parameter int SEGMENT_SLOTS = 8,
	parameter int MAX_SEGMENTS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [6:0] slot, [7] zero
	input  logic        s_tuser,   // [0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // [6:0] granted_slot, [8:7] status, [9] reused,
	                               // [10] opened_segment, [18:11] live_count,
	                               // [23:19] segments_used
);

	localparam int SEG_W = $clog2(MAX_SEGMENTS + 1);
	localparam int CAP_W = SEG_W + $clog2(SEGMENT_SLOTS + 1);
	localparam int CMP_W = (CAP_W > COUNT_W) ? CAP_W : COUNT_W;
	localparam logic [SEG_W-1:0] SegMax = SEG_W'(MAX_SEGMENTS);
	localparam logic [CMP_W-1:0] SegSlots = CMP_W'(SEGMENT_SLOTS);

	logic               valid_s1;
	cmd_t               cmd_s1;
	logic [SLOT_W-1:0]  slot_s1;

	logic [COUNT_W-1:0] bump_q, bump_d;
	logic [COUNT_W-1:0] count_q, count_d;
	logic [SEG_W-1:0]   seg_q, seg_d;
	logic [QADDR_W-1:0] head_q, head_d;
	logic [QADDR_W-1:0] tail_q, tail_d;
	logic [FILL_W-1:0]  fill_q, fill_d;

	logic               out_valid_q;
	result_t            out_q, res;

	logic               fire;
	logic               we;
	logic [CMP_W-1:0]   cap;
	logic               byp_q;
	logic [SLOT_W-1:0]  byp_data_q;
	logic [SLOT_W-1:0]  ram_rdata;
	logic [SLOT_W-1:0]  head_data;

	assign fire     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || fire;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	assign cap       = CMP_W'(seg_q) * SegSlots;
	assign head_data = byp_q ? byp_data_q : ram_rdata;

	always_comb begin
		bump_d  = bump_q;
		count_d = count_q;
		seg_d   = seg_q;
		head_d  = head_q;
		tail_d  = tail_q;
		fill_d  = fill_q;
		we      = 1'b0;
		res     = '0;
		res.status = ST_OK;
		if (fire) begin
			if (cmd_s1 == CMD_ALLOC) begin
				if (fill_q != '0) begin
					res.granted_slot = head_data;
					res.reused       = 1'b1;
					head_d = head_q + 1'b1;
					fill_d = fill_q - 1'b1;
					if (count_q != COUNT_MAX) count_d = count_q + 1'b1;
				end else if (CMP_W'(bump_q) < cap && bump_q < SLOT_LIMIT) begin
					res.granted_slot = bump_q[SLOT_W-1:0];
					bump_d = bump_q + 1'b1;
					if (count_q != COUNT_MAX) count_d = count_q + 1'b1;
				end else if (seg_q < SegMax && bump_q < SLOT_LIMIT) begin
					res.granted_slot   = bump_q[SLOT_W-1:0];
					res.opened_segment = 1'b1;
					seg_d  = seg_q + 1'b1;
					bump_d = bump_q + 1'b1;
					if (count_q != COUNT_MAX) count_d = count_q + 1'b1;
				end else begin
					res.status = ST_NO_ROOM;
				end
			end else begin
				if ({1'b0, slot_s1} >= bump_q || fill_q >= FILL_FULL) begin
					res.status = ST_REJECTED;
				end else begin
					we     = 1'b1;
					tail_d = tail_q + 1'b1;
					fill_d = fill_q + 1'b1;
					if (count_q != '0) count_d = count_q - 1'b1;
				end
			end
		end
		res.live_count    = count_d;
		res.segments_used = 5'(seg_d);
	end

	ssa_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk  (clk),
		.we   (we),
		.waddr(tail_q),
		.wdata(slot_s1),
		.raddr(head_d),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		byp_data_q <= slot_s1;
		if (s_tready) begin
			cmd_s1  <= cmd_t'(s_tuser);
			slot_s1 <= s_tdata[SLOT_W-1:0];
		end
		if (fire) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			byp_q       <= 1'b0;
			bump_q      <= '0;
			count_q     <= '0;
			seg_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			fill_q      <= '0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			byp_q   <= we && (tail_q == head_d);
			bump_q  <= bump_d;
			count_q <= count_d;
			seg_q   <= seg_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			fill_q  <= fill_d;
		end
	end

endmodule

>>> rtl/core/ssa_ram.sv
// Generic simple dual-port RAM with a registered read port.
// One write and one read address per cycle; read returns old data on a collision.
// No dependencies.
module ssa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> sim/tb_segmented_slot_allocator.sv
// Testbench for segmented_slot_allocator: directed and random allocate/release words,
// bursty input, patterned output stalls, and a scoreboard with its own allocator predictor.
// Depends on ssa_pkg and the RTL of segmented_slot_allocator.
module tb_segmented_slot_allocator
	import ssa_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SEG_SLOTS = 8;
	localparam int SEG_MAX   = 16;
	localparam int RANDOM_WORDS = 700;

	typedef enum int {MIX_ALLOC, MIX_RELEASE, MIX_EVEN, MIX_FLOOD} mix_t;

	class alloc_scoreboard;
		int unsigned bump_ptr;
		int unsigned live;
		int unsigned segs;
		logic [SLOT_W-1:0] free_list[$];
		result_t expected_results[$];
		int errors;

		function new();
			bump_ptr = 0;
			live = 0;
			segs = 0;
			errors = 0;
		endfunction

		function status_t note_request(cmd_t c, logic [SLOT_W-1:0] s);
			result_t r;
			r = '0;
			r.status = ST_OK;
			if (c == CMD_ALLOC) begin
				if (free_list.size() > 0) begin
					r.granted_slot = free_list.pop_front();
					r.reused = 1'b1;
				end else if (bump_ptr < segs * SEG_SLOTS && bump_ptr < QUEUE_DEPTH) begin
					r.granted_slot = bump_ptr[SLOT_W-1:0];
					bump_ptr++;
				end else if (segs < SEG_MAX && bump_ptr < QUEUE_DEPTH) begin
					segs++;
					r.opened_segment = 1'b1;
					r.granted_slot = bump_ptr[SLOT_W-1:0];
					bump_ptr++;
				end else begin
					r.status = ST_NO_ROOM;
				end
				if (r.status == ST_OK && live < 255)
					live++;
			end else begin
				if (s >= bump_ptr || free_list.size() >= QUEUE_DEPTH) begin
					r.status = ST_REJECTED;
				end else begin
					free_list = {free_list, s};
					if (live > 0)
						live--;
				end
			end
			r.live_count = live[COUNT_W-1:0];
			r.segments_used = segs[4:0];
			expected_results = {expected_results, r};
			return r.status;
		endfunction

		function void check_result(result_t got);
			result_t exp_r;
			bit bad;
			if (expected_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result word %h", got);
				return;
			end
			exp_r = expected_results.pop_front();
			bad = (got.granted_slot !== exp_r.granted_slot) || (got.status !== exp_r.status)
				|| (got.reused !== exp_r.reused) || (got.opened_segment !== exp_r.opened_segment)
				|| (got.live_count !== exp_r.live_count)
				|| (got.segments_used !== exp_r.segments_used);
			if (bad) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch: slot %0d/%0d status %0d/%0d reused %0b/%0b ",
						"opened %0b/%0b live %0d/%0d segs %0d/%0d (expected/actual)"},
						exp_r.granted_slot, got.granted_slot, exp_r.status, got.status,
						exp_r.reused, got.reused, exp_r.opened_segment, got.opened_segment,
						exp_r.live_count, got.live_count, exp_r.segments_used, got.segments_used);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;

	alloc_scoreboard sb;
	int burst_left;
	int taken;

	segmented_slot_allocator #(
		.SEGMENT_SLOTS(SEG_SLOTS),
		.MAX_SEGMENTS(SEG_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	initial begin
		#2_000_000;
		$display("** segmented_slot_allocator: FAILED **");
		$finish;
	end

	task automatic send_word(input cmd_t c, input logic [SLOT_W-1:0] s, output status_t st);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= c;
		s_tdata <= {1'b0, s};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		st = sb.note_request(c, s);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	function automatic logic [SLOT_W-1:0] pick_slot(bit mostly_valid);
		if (sb.bump_ptr == 0 || (!mostly_valid && $urandom_range(0, 3) == 0)
				|| $urandom_range(0, 15) == 0)
			return SLOT_W'($urandom_range(0, 127));
		return SLOT_W'($urandom_range(0, sb.bump_ptr - 1));
	endfunction

	// receiver: patterned stalls plus one long hold-off
	initial begin
		int pattern;
		int pattern_left;
		int hold_left;
		bit held;
		pattern = 0;
		pattern_left = 0;
		hold_left = 0;
		held = 0;
		taken = 0;
		m_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				sb.check_result(result_t'(m_tdata));
				taken++;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!held && taken >= 300) begin
				held = 1;
				hold_left = 200;
				m_tready <= 1'b0;
			end else begin
				if (pattern_left == 0) begin
					pattern = $urandom_range(0, 3);
					pattern_left = $urandom_range(16, 96);
				end else begin
					pattern_left--;
				end
				case (pattern)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	initial begin
		status_t st;
		mix_t mix;
		int sent;
		int len;
		int rel_pct;
		int no_room;
		bit flooded;
		cmd_t c;
		sb = new();
		burst_left = 0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= CMD_ALLOC;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(CMD_ALLOC, 7'd0, st);
		send_word(CMD_RELEASE, 7'd0, st);
		send_word(CMD_RELEASE, 7'd0, st);
		send_word(CMD_RELEASE, 7'd127, st);
		send_word(CMD_RELEASE, 7'd1, st);
		send_word(CMD_ALLOC, 7'd127, st);
		send_word(CMD_ALLOC, 7'd0, st);
		repeat (8) send_word(CMD_ALLOC, 7'h55, st);
		send_word(CMD_RELEASE, 7'd8, st);
		send_word(CMD_RELEASE, 7'd9, st);
		send_word(CMD_ALLOC, 7'h2a, st);

		sent = 0;
		flooded = 0;
		while (sent < RANDOM_WORDS) begin
			mix = mix_t'($urandom_range(0, 2));
			len = $urandom_range(20, 80);
			if (!flooded && sent > 300) begin
				mix = MIX_FLOOD;
				len = 150;
				flooded = 1;
			end
			case (mix)
				MIX_ALLOC:   rel_pct = 20;
				MIX_RELEASE: rel_pct = 80;
				MIX_EVEN:    rel_pct = 50;
				default:     rel_pct = 100;
			endcase
			for (int i = 0; i < len; i++) begin
				c = ($urandom_range(0, 99) < rel_pct) ? CMD_RELEASE : CMD_ALLOC;
				send_word(c, pick_slot(mix == MIX_FLOOD), st);
				sent++;
			end
		end

		// drain the free list and the slot space until no room is left
		no_room = 0;
		for (int i = 0; i < 300 && no_room < 5; i++) begin
			send_word(CMD_ALLOC, SLOT_W'($urandom_range(0, 127)), st);
			if (st == ST_NO_ROOM)
				no_room++;
		end
		for (int i = 0; i < 40; i++) begin
			c = ($urandom_range(0, 1) == 0) ? CMD_RELEASE : CMD_ALLOC;
			send_word(c, pick_slot(1'b0), st);
		end

		s_tvalid <= 1'b0;
		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.expected_results.size() == 0)
			$display("** segmented_slot_allocator: PASSED **");
		else
			$display("** segmented_slot_allocator: FAILED **");
		$finish;
	end

endmodule
